// ===== src/a64dec_pkg.sv =====
package a64dec_pkg;

  // ALU operation codes
  localparam logic [3:0] ALU_NONE  = 4'd0;
  localparam logic [3:0] ALU_AND   = 4'd1;
  localparam logic [3:0] ALU_OR    = 4'd2;
  localparam logic [3:0] ALU_ADD   = 4'd3;
  localparam logic [3:0] ALU_MUL   = 4'd4;
  localparam logic [3:0] ALU_XOR   = 4'd5;
  localparam logic [3:0] ALU_SUB   = 4'd6;
  localparam logic [3:0] ALU_TESTZ = 4'd7;
  localparam logic [3:0] ALU_MOVE  = 4'd8;
  localparam logic [3:0] ALU_LSL   = 4'd9;
  localparam logic [3:0] ALU_LSR   = 4'd10;

  // control-transfer kinds
  localparam logic [2:0] CK_NONE  = 3'd0;
  localparam logic [2:0] CK_BCOND = 3'd1;
  localparam logic [2:0] CK_CBZ   = 3'd2;
  localparam logic [2:0] CK_CBNZ  = 3'd3;
  localparam logic [2:0] CK_B     = 3'd4;
  localparam logic [2:0] CK_BR    = 3'd5;
  localparam logic [2:0] CK_HALT  = 3'd6;

  // memory operations
  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  // immediate extraction formats, resolved in the last stage
  localparam logic [2:0] IMM_ZERO = 3'd0;
  localparam logic [2:0] IMM_U12  = 3'd1; // bits 21:10
  localparam logic [2:0] IMM_U16  = 3'd2; // bits 20:5
  localparam logic [2:0] IMM_IMMR = 3'd3; // bits 21:16
  localparam logic [2:0] IMM_LSL  = 3'd4; // ~imms, 6 bits
  localparam logic [2:0] IMM_S19  = 3'd5; // sext(23:5) * 4
  localparam logic [2:0] IMM_S26  = 3'd6; // sext(25:0) * 4
  localparam logic [2:0] IMM_S9   = 3'd7; // sext(20:12)

  localparam logic [5:0] IMMS_ALL = 6'h3f;

  localparam int INSN_W = 32;
  localparam int IMM_W  = 28;

  // encoding group of the word, at most one bit set
  typedef struct packed {
    logic dp_imm;
    logic branch;
    logic ldst;
    logic dp_reg;
  } group_t;

  // decoded controls handed from stage 2 to stage 3
  typedef struct packed {
    logic [3:0] alu_op;
    logic       operand_is_imm;
    logic [2:0] imm_kind;
    logic [2:0] control_kind;
    logic [3:0] cond_code;
    logic [1:0] mem_op;
    logic [1:0] mem_size;
    logic       reg_write;
    logic       set_flags;
    logic       reg2loc;
  } ctrl_t;

endpackage

// ===== src/a64dec_group.sv =====
// Stage 1: register the word and classify its encoding group.
module a64dec_group (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [a64dec_pkg::INSN_W-1:0]   instruction,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [a64dec_pkg::INSN_W-1:0]   insn,
  output a64dec_pkg::group_t              group
);

  logic                 valid;
  a64dec_pkg::group_t   group_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // group from bits 28:25
  always_comb begin
    group_next.dp_imm = (instruction[28:26] == 3'b100);
    group_next.branch = (instruction[28:26] == 3'b101);
    group_next.ldst   = (instruction[27] && !instruction[25]);
    group_next.dp_reg = (instruction[27:25] == 3'b101);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      insn  <= instruction;
      group <= group_next;
    end
  end

endmodule

// ===== src/a64dec_ctrl.sv =====
// Stage 2: per-group control decode.
module a64dec_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [a64dec_pkg::INSN_W-1:0]   in_insn,
  input  a64dec_pkg::group_t              group,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [a64dec_pkg::INSN_W-1:0]   insn,
  output a64dec_pkg::ctrl_t               ctrl
);

  logic               valid;
  a64dec_pkg::ctrl_t  ctrl_next;
  logic [2:0]         sub_op;
  logic [5:0]         imms;
  logic [5:0]         immr;
  logic [2:0]         top;
  logic [3:0]         o1;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  assign sub_op = in_insn[25:23];
  assign imms   = in_insn[15:10];
  assign immr   = in_insn[21:16];
  assign top    = in_insn[31:29];
  assign o1     = in_insn[25:22];

  always_comb begin
    ctrl_next                = '0;
    ctrl_next.alu_op         = a64dec_pkg::ALU_NONE;
    ctrl_next.imm_kind       = a64dec_pkg::IMM_ZERO;
    ctrl_next.control_kind   = a64dec_pkg::CK_NONE;
    ctrl_next.mem_op         = a64dec_pkg::MEM_NONE;
    if (group.dp_imm) begin
      ctrl_next.operand_is_imm = 1'b1;
      ctrl_next.reg_write      = 1'b1;
      if (sub_op[2:1] == 2'b01) begin
        ctrl_next.alu_op    = in_insn[30] ? a64dec_pkg::ALU_SUB : a64dec_pkg::ALU_ADD;
        ctrl_next.set_flags = in_insn[29];
        ctrl_next.imm_kind  = a64dec_pkg::IMM_U12;
      end else if (sub_op == 3'd5) begin
        ctrl_next.alu_op   = a64dec_pkg::ALU_MOVE;
        ctrl_next.imm_kind = a64dec_pkg::IMM_U16;
      end else if (sub_op == 3'd6) begin
        // bitfield: only the LSR and LSL aliases are decoded
        if (imms == a64dec_pkg::IMMS_ALL) begin
          ctrl_next.alu_op   = a64dec_pkg::ALU_LSR;
          ctrl_next.imm_kind = a64dec_pkg::IMM_IMMR;
        end else if ({1'b0, imms} + 7'd1 == {1'b0, immr}) begin
          ctrl_next.alu_op   = a64dec_pkg::ALU_LSL;
          ctrl_next.imm_kind = a64dec_pkg::IMM_LSL;
        end
      end
    end else if (group.branch) begin
      if (top == 3'd6) begin
        if (!o1[3] && !o1[2]) begin
          ctrl_next.control_kind = a64dec_pkg::CK_HALT;
        end else if (o1[3]) begin
          ctrl_next.control_kind = a64dec_pkg::CK_BR;
        end
      end else if (top == 3'd2 && !o1[3]) begin
        ctrl_next.control_kind = a64dec_pkg::CK_BCOND;
        ctrl_next.cond_code    = in_insn[3:0];
        ctrl_next.imm_kind     = a64dec_pkg::IMM_S19;
      end else if (top[1:0] == 2'd0) begin
        ctrl_next.control_kind = a64dec_pkg::CK_B;
        ctrl_next.imm_kind     = a64dec_pkg::IMM_S26;
      end else if (top[1:0] == 2'd1 && !o1[3]) begin
        ctrl_next.control_kind = in_insn[24] ? a64dec_pkg::CK_CBNZ : a64dec_pkg::CK_CBZ;
        ctrl_next.alu_op       = a64dec_pkg::ALU_TESTZ;
        ctrl_next.reg2loc      = 1'b1;
        ctrl_next.imm_kind     = a64dec_pkg::IMM_S19;
      end
    end else if (group.ldst) begin
      ctrl_next.imm_kind       = a64dec_pkg::IMM_S9;
      ctrl_next.operand_is_imm = 1'b1;
      ctrl_next.alu_op         = a64dec_pkg::ALU_ADD;
      // unscaled-offset form
      if (in_insn[29:28] == 2'b11 && !in_insn[24] && !in_insn[21] &&
          in_insn[11:10] == 2'b00) begin
        if (in_insn[23:22] == 2'd0) begin
          ctrl_next.mem_op  = a64dec_pkg::MEM_STORE;
          ctrl_next.reg2loc = 1'b1;
        end else if (in_insn[23:22] == 2'd1) begin
          ctrl_next.mem_op    = a64dec_pkg::MEM_LOAD;
          ctrl_next.reg_write = 1'b1;
        end
        ctrl_next.mem_size = in_insn[31:30];
      end
    end else if (group.dp_reg) begin
      ctrl_next.reg_write = 1'b1;
      if (!in_insn[28]) begin
        if (!in_insn[24]) begin
          // logical shifted register
          case (in_insn[30:29])
            2'd1:    ctrl_next.alu_op = a64dec_pkg::ALU_OR;
            2'd2:    ctrl_next.alu_op = a64dec_pkg::ALU_XOR;
            default: ctrl_next.alu_op = a64dec_pkg::ALU_AND;
          endcase
          ctrl_next.set_flags = (in_insn[30:29] == 2'd3);
        end else begin
          ctrl_next.alu_op    = in_insn[30] ? a64dec_pkg::ALU_SUB : a64dec_pkg::ALU_ADD;
          ctrl_next.set_flags = in_insn[29];
          ctrl_next.imm_kind  = a64dec_pkg::IMM_U12;
        end
      end else if (in_insn[24]) begin
        ctrl_next.alu_op = a64dec_pkg::ALU_MUL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      insn <= in_insn;
      ctrl <= ctrl_next;
    end
  end

endmodule

// ===== src/a64dec_fields.sv =====
// Stage 3: immediate extraction, register selects, output register.
module a64dec_fields (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [a64dec_pkg::INSN_W-1:0]        insn,
  input  a64dec_pkg::ctrl_t                    ctrl,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [3:0]                           alu_op,
  output logic                                 operand_is_imm,
  output logic signed [a64dec_pkg::IMM_W-1:0]  immediate,
  output logic [4:0]                           src1_reg,
  output logic [4:0]                           src2_reg,
  output logic [4:0]                           dest_reg,
  output logic [2:0]                           control_kind,
  output logic [3:0]                           cond_code,
  output logic [1:0]                           mem_op,
  output logic [1:0]                           mem_size,
  output logic                                 reg_write,
  output logic                                 set_flags
);

  localparam int W = a64dec_pkg::IMM_W;

  logic                  valid;
  logic signed [W-1:0]   imm_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // immediate by format
  always_comb begin
    case (ctrl.imm_kind)
      a64dec_pkg::IMM_U12:  imm_next = {{(W-12){1'b0}}, insn[21:10]};
      a64dec_pkg::IMM_U16:  imm_next = {{(W-16){1'b0}}, insn[20:5]};
      a64dec_pkg::IMM_IMMR: imm_next = {{(W-6){1'b0}}, insn[21:16]};
      a64dec_pkg::IMM_LSL:  imm_next = {{(W-6){1'b0}}, ~insn[15:10]};
      a64dec_pkg::IMM_S19:  imm_next = {{(W-21){insn[23]}}, insn[23:5], 2'b00};
      a64dec_pkg::IMM_S26:  imm_next = {insn[25:0], 2'b00};
      a64dec_pkg::IMM_S9:   imm_next = {{(W-9){insn[20]}}, insn[20:12]};
      default:              imm_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      alu_op         <= ctrl.alu_op;
      operand_is_imm <= ctrl.operand_is_imm;
      immediate      <= imm_next;
      src1_reg       <= insn[9:5];
      src2_reg       <= ctrl.reg2loc ? insn[4:0] : insn[20:16];
      dest_reg       <= insn[4:0];
      control_kind   <= ctrl.control_kind;
      cond_code      <= ctrl.cond_code;
      mem_op         <= ctrl.mem_op;
      mem_size       <= ctrl.mem_size;
      reg_write      <= ctrl.reg_write;
      set_flags      <= ctrl.set_flags;
    end
  end

endmodule

// ===== src/arm64_subset_instruction_decoder.sv =====
// Channel    Handshake              Payload
// ---------  ---------------------  ----------------------------------------
// input      in_valid / in_ready    instruction
// output     out_valid / out_ready  alu_op .. set_flags (12 decoded fields)
//
// Three register stages: group classify, control decode, field extract.
// One request is accepted per cycle in steady state, while out_ready is high.
// Each stage holds its own valid bit; a stage takes a new request when it is
// empty or the stage after it moves, so out_ready low stalls without loss.
// Synchronous reset clears the valid bits only.
module arm64_subset_instruction_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [a64dec_pkg::INSN_W-1:0]        instruction,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [3:0]                           alu_op,
  output logic                                 operand_is_imm,
  output logic signed [a64dec_pkg::IMM_W-1:0]  immediate,
  output logic [4:0]                           src1_reg,
  output logic [4:0]                           src2_reg,
  output logic [4:0]                           dest_reg,
  output logic [2:0]                           control_kind,
  output logic [3:0]                           cond_code,
  output logic [1:0]                           mem_op,
  output logic [1:0]                           mem_size,
  output logic                                 reg_write,
  output logic                                 set_flags
);

  logic                           s1_valid, s1_ready;
  logic [a64dec_pkg::INSN_W-1:0]  s1_insn;
  a64dec_pkg::group_t             s1_group;
  logic                           s2_valid, s2_ready;
  logic [a64dec_pkg::INSN_W-1:0]  s2_insn;
  a64dec_pkg::ctrl_t              s2_ctrl;

  // stage 1
  a64dec_group u_group (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .instruction (instruction),
    .out_valid   (s1_valid),
    .out_ready   (s1_ready),
    .insn        (s1_insn),
    .group       (s1_group)
  );

  // stage 2
  a64dec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_insn   (s1_insn),
    .group     (s1_group),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .insn      (s2_insn),
    .ctrl      (s2_ctrl)
  );

  // stage 3
  a64dec_fields u_fields (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s2_valid),
    .in_ready       (s2_ready),
    .insn           (s2_insn),
    .ctrl           (s2_ctrl),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .alu_op         (alu_op),
    .operand_is_imm (operand_is_imm),
    .immediate      (immediate),
    .src1_reg       (src1_reg),
    .src2_reg       (src2_reg),
    .dest_reg       (dest_reg),
    .control_kind   (control_kind),
    .cond_code      (cond_code),
    .mem_op         (mem_op),
    .mem_size       (mem_size),
    .reg_write      (reg_write),
    .set_flags      (set_flags)
  );

endmodule

// ===== src/a64dec_checker.sv =====
// Port-level checks for the decoder.
module a64dec_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [3:0]                           alu_op,
  input logic signed [a64dec_pkg::IMM_W-1:0]  immediate,
  input logic [4:0]                           src2_reg,
  input logic [4:0]                           dest_reg,
  input logic [2:0]                           control_kind,
  input logic [1:0]                           mem_op,
  input logic                                 reg_write
);

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(alu_op) && $stable(immediate)
      && $stable(control_kind) && $stable(mem_op))
    else $error("stalled result changed");

  // compare-branch tests the destination field as second source
  a_cb_src2: assert property (@(posedge clk) disable iff (rst)
    out_valid && (control_kind == a64dec_pkg::CK_CBZ || control_kind == a64dec_pkg::CK_CBNZ)
      |-> alu_op == a64dec_pkg::ALU_TESTZ && src2_reg == dest_reg && !reg_write)
    else $error("compare-branch controls inconsistent");

  // stores read the data register from the destination field and write nothing
  a_store_src2: assert property (@(posedge clk) disable iff (rst)
    out_valid && mem_op == a64dec_pkg::MEM_STORE
      |-> src2_reg == dest_reg && !reg_write && alu_op == a64dec_pkg::ALU_ADD)
    else $error("store controls inconsistent");

endmodule

bind arm64_subset_instruction_decoder a64dec_checker u_a64dec_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .alu_op       (alu_op),
  .immediate    (immediate),
  .src2_reg     (src2_reg),
  .dest_reg     (dest_reg),
  .control_kind (control_kind),
  .mem_op       (mem_op),
  .reg_write    (reg_write)
);

// ===== test/arm64_subset_instruction_decoder_tb.sv =====
module arm64_subset_instruction_decoder_tb;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int CHUNK_ITEMS    = 150;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;

  // one decoded instruction, fields in port order
  typedef struct packed {
    logic [3:0]                   alu_op;
    logic                         operand_is_imm;
    logic [a64dec_pkg::IMM_W-1:0] immediate;
    logic [4:0]                   src1_reg;
    logic [4:0]                   src2_reg;
    logic [4:0]                   dest_reg;
    logic [2:0]                   control_kind;
    logic [3:0]                   cond_code;
    logic [1:0]                   mem_op;
    logic [1:0]                   mem_size;
    logic                         reg_write;
    logic                         set_flags;
  } decoded_t;

  // instruction shapes for the random part
  typedef enum int {
    F_ADDSUB_IMM,
    F_MOVZ,
    F_LSL,
    F_LSR,
    F_BITFIELD_OTHER,
    F_IMM_OTHER,
    F_BRANCH,
    F_BCOND,
    F_CMP_BRANCH,
    F_BR_HLT,
    F_LDST_UNSCALED,
    F_LDST_OTHER,
    F_LOGIC_REG,
    F_ADDSUB_REG,
    F_MUL,
    F_NOISE
  } form_t;

  class decode_scoreboard;
    decoded_t expected_decodes[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // decode one word into the controls the pipeline expects
    function decoded_t decode_word(logic [31:0] w);
      decoded_t   d;
      logic [3:0] grp;
      logic [2:0] sub;
      logic [2:0] top;
      logic [3:0] o1;
      logic [3:0] o2;
      logic [5:0] imms;
      logic [5:0] immr;
      logic [1:0] opc;
      logic       reg2loc;
      d        = '0;
      reg2loc  = 1'b0;
      grp      = w[28:25];
      d.src1_reg = w[9:5];
      d.dest_reg = w[4:0];
      if (grp[3:1] == 3'b100) begin
        // data processing, immediate
        sub              = w[25:23];
        d.operand_is_imm = 1'b1;
        d.reg_write      = 1'b1;
        if (sub[2:1] == 2'b01) begin
          d.alu_op    = w[30] ? a64dec_pkg::ALU_SUB : a64dec_pkg::ALU_ADD;
          d.set_flags = w[29];
          d.immediate = {16'b0, w[21:10]};
        end else if (sub == 3'd5) begin
          d.alu_op    = a64dec_pkg::ALU_MOVE;
          d.immediate = {12'b0, w[20:5]};
        end else if (sub == 3'd6) begin
          imms = w[15:10];
          immr = w[21:16];
          if (imms == a64dec_pkg::IMMS_ALL) begin
            d.alu_op    = a64dec_pkg::ALU_LSR;
            d.immediate = {22'b0, immr};
          end else if (({1'b0, imms} + 7'd1) == {1'b0, immr}) begin
            d.alu_op    = a64dec_pkg::ALU_LSL;
            d.immediate = {22'b0, ~imms};
          end
        end
      end else if (grp[3:1] == 3'b101) begin
        // branches and system
        top = w[31:29];
        o1  = w[25:22];
        if (top == 3'd6) begin
          if (o1 < 4'd4) d.control_kind = a64dec_pkg::CK_HALT;
          else if (o1 >= 4'd8) d.control_kind = a64dec_pkg::CK_BR;
        end else if (top == 3'd2 && o1 < 4'd8) begin
          d.control_kind = a64dec_pkg::CK_BCOND;
          d.cond_code    = w[3:0];
          d.immediate    = {{7{w[23]}}, w[23:5], 2'b00};
        end else if (top[1:0] == 2'd0) begin
          d.control_kind = a64dec_pkg::CK_B;
          d.immediate    = {w[25:0], 2'b00};
        end else if (top[1:0] == 2'd1 && o1 < 4'd8) begin
          d.control_kind = w[24] ? a64dec_pkg::CK_CBNZ : a64dec_pkg::CK_CBZ;
          d.alu_op       = a64dec_pkg::ALU_TESTZ;
          reg2loc        = 1'b1;
          d.immediate    = {{7{w[23]}}, w[23:5], 2'b00};
        end
      end else if (!grp[0] && grp[2]) begin
        // loads and stores: offset always given, access only in unscaled form
        d.immediate      = {{19{w[20]}}, w[20:12]};
        d.operand_is_imm = 1'b1;
        d.alu_op         = a64dec_pkg::ALU_ADD;
        if (w[29:28] == 2'b11 && !w[24] && !w[21] && w[11:10] == 2'b00) begin
          opc = w[23:22];
          if (opc == 2'd0) begin
            d.mem_op = a64dec_pkg::MEM_STORE;
            reg2loc  = 1'b1;
          end else if (opc == 2'd1) begin
            d.mem_op    = a64dec_pkg::MEM_LOAD;
            d.reg_write = 1'b1;
          end
          d.mem_size = w[31:30];
        end
      end else if (grp[2:0] == 3'b101) begin
        // data processing, register
        o2          = w[24:21];
        d.reg_write = 1'b1;
        if (!w[28]) begin
          if (o2 < 4'd8) begin
            opc      = w[30:29];
            d.alu_op = (opc == 2'd1) ? a64dec_pkg::ALU_OR :
                       (opc == 2'd2) ? a64dec_pkg::ALU_XOR : a64dec_pkg::ALU_AND;
            if (opc == 2'd3) d.set_flags = 1'b1;
          end else begin
            d.alu_op    = w[30] ? a64dec_pkg::ALU_SUB : a64dec_pkg::ALU_ADD;
            d.set_flags = w[29];
            d.immediate = {16'b0, w[21:10]};
          end
        end else if (o2 >= 4'd8) begin
          d.alu_op = a64dec_pkg::ALU_MUL;
        end
      end
      d.src2_reg = reg2loc ? w[4:0] : w[20:16];
      return d;
    endfunction

    function void note_request(logic [31:0] w);
      expected_decodes.push_back(decode_word(w));
    endfunction

    function void check_result(decoded_t got);
      decoded_t want;
      if (expected_decodes.size() == 0) begin
        $error("decoded result with no request outstanding");
        errors++;
        return;
      end
      want = expected_decodes.pop_front();
      if (got.alu_op !== want.alu_op) begin
        $error("alu_op: expected %0d, got %0d", want.alu_op, got.alu_op);
        errors++;
      end
      if (got.operand_is_imm !== want.operand_is_imm) begin
        $error("operand_is_imm: expected %0d, got %0d", want.operand_is_imm,
               got.operand_is_imm);
        errors++;
      end
      if (got.immediate !== want.immediate) begin
        $error("immediate: expected %h, got %h", want.immediate, got.immediate);
        errors++;
      end
      if (got.src1_reg !== want.src1_reg) begin
        $error("src1_reg: expected %0d, got %0d", want.src1_reg, got.src1_reg);
        errors++;
      end
      if (got.src2_reg !== want.src2_reg) begin
        $error("src2_reg: expected %0d, got %0d", want.src2_reg, got.src2_reg);
        errors++;
      end
      if (got.dest_reg !== want.dest_reg) begin
        $error("dest_reg: expected %0d, got %0d", want.dest_reg, got.dest_reg);
        errors++;
      end
      if (got.control_kind !== want.control_kind) begin
        $error("control_kind: expected %0d, got %0d", want.control_kind,
               got.control_kind);
        errors++;
      end
      if (got.cond_code !== want.cond_code) begin
        $error("cond_code: expected %0d, got %0d", want.cond_code, got.cond_code);
        errors++;
      end
      if (got.mem_op !== want.mem_op) begin
        $error("mem_op: expected %0d, got %0d", want.mem_op, got.mem_op);
        errors++;
      end
      if (got.mem_size !== want.mem_size) begin
        $error("mem_size: expected %0d, got %0d", want.mem_size, got.mem_size);
        errors++;
      end
      if (got.reg_write !== want.reg_write) begin
        $error("reg_write: expected %0d, got %0d", want.reg_write, got.reg_write);
        errors++;
      end
      if (got.set_flags !== want.set_flags) begin
        $error("set_flags: expected %0d, got %0d", want.set_flags, got.set_flags);
        errors++;
      end
    endfunction

    function int pending();
      return expected_decodes.size();
    endfunction
  endclass

  logic                                clk;
  logic                                rst         = 1'b1;
  logic                                in_valid    = 1'b0;
  logic                                in_ready;
  logic [a64dec_pkg::INSN_W-1:0]       instruction = '0;
  logic                                out_valid;
  logic                                out_ready   = 1'b0;
  logic [3:0]                          alu_op;
  logic                                operand_is_imm;
  logic signed [a64dec_pkg::IMM_W-1:0] immediate;
  logic [4:0]                          src1_reg;
  logic [4:0]                          src2_reg;
  logic [4:0]                          dest_reg;
  logic [2:0]                          control_kind;
  logic [3:0]                          cond_code;
  logic [1:0]                          mem_op;
  logic [1:0]                          mem_size;
  logic                                reg_write;
  logic                                set_flags;

  decoded_t         observed;
  decode_scoreboard sb;
  logic             steady_mode = 1'b0;
  int               ready_hold  = 0;
  int               idle_cycles = 0;

  assign observed = {alu_op, operand_is_imm, immediate, src1_reg, src2_reg, dest_reg,
                     control_kind, cond_code, mem_op, mem_size, reg_write, set_flags};

  arm64_subset_instruction_decoder i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .instruction    (instruction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .alu_op         (alu_op),
    .operand_is_imm (operand_is_imm),
    .immediate      (immediate),
    .src1_reg       (src1_reg),
    .src2_reg       (src2_reg),
    .dest_reg       (dest_reg),
    .control_kind   (control_kind),
    .cond_code      (cond_code),
    .mem_op         (mem_op),
    .mem_size       (mem_size),
    .reg_write      (reg_write),
    .set_flags      (set_flags)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic form_t pick_form();
    if ($urandom_range(0, 99) < 15) return F_NOISE;
    return form_t'($urandom_range(0, F_NOISE - 1));
  endfunction

  // random word with the bits that select the given shape forced
  function automatic logic [31:0] make_word(form_t f);
    logic [31:0] w;
    logic [5:0]  imms;
    int          r;
    w = $urandom;
    case (f)
      F_ADDSUB_IMM: w[28:24] = 5'b10001;
      F_MOVZ:       w[28:23] = 6'b100101;
      F_LSL: begin
        w[28:23]  = 6'b100110;
        imms      = 6'($urandom_range(0, 62));
        w[15:10]  = imms;
        w[21:16]  = imms + 6'd1;
      end
      F_LSR: begin
        w[28:23] = 6'b100110;
        w[15:10] = a64dec_pkg::IMMS_ALL;
      end
      F_BITFIELD_OTHER: w[28:23] = 6'b100110;
      F_IMM_OTHER: begin
        w[28:26] = 3'b100;
        case ($urandom_range(0, 3))
          0:       w[25:23] = 3'd0;
          1:       w[25:23] = 3'd1;
          2:       w[25:23] = 3'd4;
          default: w[25:23] = 3'd7;
        endcase
      end
      F_BRANCH:     w[30:26] = 5'b00101;
      F_BCOND:      w[31:25] = 7'b0101010;
      F_CMP_BRANCH: w[30:25] = 6'b011010;
      F_BR_HLT:     w[31:26] = 6'b110101;
      F_LDST_UNSCALED: begin
        w[29:27] = 3'b111;
        w[25:24] = 2'b00;
        w[21]    = 1'b0;
        w[11:10] = 2'b00;
        r = $urandom_range(0, 9);
        w[23:22] = (r < 4) ? 2'd0 : (r < 8) ? 2'd1 : 2'($urandom_range(2, 3));
        r = $urandom_range(0, 9);
        w[31:30] = (r < 3) ? 2'd0 : (r < 6) ? 2'd1 : (r < 9) ? 2'd3 : 2'd2;
      end
      F_LDST_OTHER: begin
        w[27] = 1'b1;
        w[25] = 1'b0;
      end
      F_LOGIC_REG:  w[28:24] = 5'b01010;
      F_ADDSUB_REG: w[28:24] = 5'b01011;
      F_MUL: begin
        w[28:25] = 4'b1101;
        w[24]    = ($urandom_range(0, 3) != 0);
      end
      default: ;
    endcase
    return w;
  endfunction

  // hold valid from the first cycle after the gap until the request is taken
  task automatic send_word(input logic [31:0] w, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    instruction <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  // record accepted requests
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_request(instruction);
  end

  // check results and randomize the receiver's stalls
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(observed);
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady_mode) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 60) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // stop if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("arm64_subset_instruction_decoder_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] directed [23] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h913F_FC41,  // add, largest immediate
      32'hF100_0421,  // subs
      32'hD2BF_FFE0,  // movz with shift, which is ignored
      32'hD37F_F800,  // lsl #1
      32'hD340_FC00,  // lsr #0
      32'hD342_0000,  // bitfield that is neither alias
      32'h9000_0000,  // immediate group, unknown sub-op
      32'h17FF_FFFF,  // b, one word back
      32'h54FF_FFE1,  // b.cond, negative offset
      32'hB500_0000,  // cbnz
      32'hD61F_03C0,  // br
      32'hD440_0000,  // hlt
      32'hF800_0020,  // stur, double
      32'h3840_0000,  // ldurb
      32'h7800_0000,  // sturh
      32'hF940_0000,  // load/store outside the unscaled form
      32'h8A02_0020,  // and, register
      32'hAB02_0020,  // adds, register
      32'h9B00_7C00   // mul
    };
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_word(directed[i], pick_gap());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % CHUNK_ITEMS == 0) steady_mode = ($urandom_range(0, 3) == 0);
      // let the pipeline drain completely once
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      send_word(make_word(pick_form()), steady_mode ? 0 : pick_gap());
    end

    in_valid <= 1'b0;
    steady_mode = 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("arm64_subset_instruction_decoder_tb: clean");
    end else begin
      $display("arm64_subset_instruction_decoder_tb: errors");
    end
    $finish;
  end

endmodule
